FILE: design/cedq_pkg.sv
`timescale 1ns / 1ps

package cedq_pkg;

	// register file of the configuration port
	localparam int CFG_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int STEP_W     = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_SIZE         = 3'd0,
		REG_JUMP_VALUE        = 3'd1,
		REG_FAILURE_THRESHOLD = 3'd2,
		REG_AGING_THRESHOLD   = 3'd3,
		REG_HEALING_THRESHOLD = 3'd4,
		REG_OCCURRENCE_LIMIT  = 3'd5
	} cfg_reg_t;

	localparam logic [STEP_W-1:0] STEP_SIZE_RST        = 7'd50;
	localparam logic [CFG_W-1:0]  JUMP_VALUE_RST       = 8'd0;
	localparam logic [CFG_W-1:0]  FAILURE_THRESHOLD_RST = 8'd2;
	localparam logic [CFG_W-1:0]  AGING_THRESHOLD_RST  = 8'd3;
	localparam logic [CFG_W-1:0]  HEALING_THRESHOLD_RST = 8'd3;
	localparam logic [CFG_W-1:0]  OCCURRENCE_LIMIT_RST = 8'd2;

	// item kinds carried on the slave tuser bit
	typedef enum logic {
		OP_REPORT   = 1'b0,
		OP_OP_CYCLE = 1'b1
	} opcode_t;

	localparam int COUNT_WIDTH_DEF = 8;
	localparam int LVL_W           = 10;
	localparam int FD_W            = 8;
	localparam int OUT_CNT_W       = 8;

	localparam logic signed [LVL_W-1:0] LVL_MAX     = 10'sd511;
	localparam logic signed [LVL_W-1:0] LVL_MIN     = -10'sd512;
	localparam logic signed [LVL_W-1:0] LVL_HI_LIM  = 10'sd127;
	localparam logic signed [LVL_W-1:0] LVL_LO_LIM  = -10'sd128;

	// qualified fault-detect codes
	localparam logic signed [FD_W-1:0] FD_FAILED    = 8'sd127;
	localparam logic signed [FD_W-1:0] FD_PREFAILED = 8'sd1;
	localparam logic signed [FD_W-1:0] FD_INITIAL   = 8'sd0;
	localparam logic signed [FD_W-1:0] FD_PREPASSED = -8'sd1;
	localparam logic signed [FD_W-1:0] FD_PASSED    = -8'sd128;
	localparam logic signed [FD_W-1:0] FD_PASS_STOP = -8'sd127;

	// status bit positions
	localparam int ST_TEST_FAILED   = 0;
	localparam int ST_QUALIFIED     = 1;
	localparam int ST_OCCURRENCE    = 2;
	localparam int ST_AGING_BIT     = 3;
	localparam int ST_HEALING_BIT   = 7;

	typedef struct packed {
		logic [OUT_CNT_W-1:0]     healing_count;
		logic [OUT_CNT_W-1:0]     aging_count;
		logic [OUT_CNT_W-1:0]     failure_count;
		logic signed [LVL_W-1:0]  debounce_level;
		logic signed [FD_W-1:0]   fault_detect;
		logic [7:0]               event_status;
	} result_t;

	localparam int RES_W      = $bits(result_t);
	localparam int M_TDATA_W  = 56;
	localparam int OQ_DEPTH   = 3;

endpackage

FILE: design/cedq_out_fifo.sv
`timescale 1ns / 1ps

module cedq_out_fifo
	import cedq_pkg::*;
#(
	parameter int WIDTH = RES_W,
	parameter int DEPTH = OQ_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             push_data,
	input  logic                         pop,
	output logic                         not_empty,
	output logic [WIDTH-1:0]             head_data,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign not_empty = (count_q != '0);
	assign head_data = entry_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: design/counter_event_debounce_qualifier_core.sv
`timescale 1ns / 1ps

// counter-based debounce qualifier for one diagnostic event. a beat on the slave side is
// either a monitor report (tuser 0, tdata bit 0 = failed) or the start of an operation cycle
// (tuser 1, tdata ignored); every beat yields exactly one result beat on the master side
// carrying the status byte, the five-level fault-detect value, the debounce level and the
// failure, aging and healing counters after that beat. a beat is registered once on entry
// and resolved in the following cycle by a single pass of adds and compares against the
// event state, so one beat per cycle is sustained while the output buffer has room, and a
// result enters that buffer from the input register. results queue in a three-entry output
// buffer, so input beats keep being taken while earlier results wait; tready drops only when
// the registered beat plus queued results fill the buffer. configuration registers are
// written through cfg_wr_en/cfg_index/cfg_data and must only change while the block is idle

module counter_event_debounce_qualifier_core
	import cedq_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	// slave side
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,  // [0] failed, [7:1] zero
	input  logic [0:0]             s_tuser,  // [0] opcode
	// master side
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_TDATA_W-1:0]   m_tdata   // [7:0] event_status, [15:8] fault_detect,
	                                         // [25:16] debounce_level, [33:26] failure_count,
	                                         // [41:34] aging_count, [49:42] healing_count,
	                                         // [55:50] zero
);

	// counters are compared against 8-bit thresholds at the wider of the two widths
	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
	localparam int INFL_W   = OQ_CNT_W + 1;

	// configuration registers
	logic [STEP_W-1:0]       step_size_q;
	logic signed [CFG_W-1:0] jump_value_q;
	logic [CFG_W-1:0]        failure_thr_q;
	logic [CFG_W-1:0]        aging_thr_q;
	logic [CFG_W-1:0]        healing_thr_q;
	logic [CFG_W-1:0]        occ_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q   <= STEP_SIZE_RST;
			jump_value_q  <= JUMP_VALUE_RST;
			failure_thr_q <= FAILURE_THRESHOLD_RST;
			aging_thr_q   <= AGING_THRESHOLD_RST;
			healing_thr_q <= HEALING_THRESHOLD_RST;
			occ_limit_q   <= OCCURRENCE_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_STEP_SIZE:         step_size_q   <= cfg_data[STEP_W-1:0];
				REG_JUMP_VALUE:        jump_value_q  <= cfg_data;
				REG_FAILURE_THRESHOLD: failure_thr_q <= cfg_data;
				REG_AGING_THRESHOLD:   aging_thr_q   <= cfg_data;
				REG_HEALING_THRESHOLD: healing_thr_q <= cfg_data;
				REG_OCCURRENCE_LIMIT:  occ_limit_q   <= cfg_data;
				default:               ; // unmapped index, write dropped
			endcase
		end
	end

	// input register
	logic     valid_s1;
	opcode_t  opcode_s1;
	logic     failed_s1;
	logic     in_accept;

	logic [OQ_CNT_W-1:0] oq_count;
	logic [INFL_W-1:0]   in_flight;

	// beats already committed to the output buffer: the registered one plus queued ones
	assign in_flight = INFL_W'(oq_count) + INFL_W'(valid_s1);
	assign s_tready  = (in_flight < INFL_W'(OQ_DEPTH));
	assign in_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			opcode_s1 <= opcode_t'(s_tuser[0]);
			failed_s1 <= s_tdata[0];
		end
	end

	// event state
	logic signed [LVL_W-1:0] level_q,   level_d;
	logic signed [FD_W-1:0]  fd_q,      fd_d;
	logic [7:0]              status_q,  status_d;
	logic [COUNT_WIDTH-1:0]  fail_cnt_q, fail_cnt_d;
	logic [COUNT_WIDTH-1:0]  aging_cnt_q, aging_cnt_d;
	logic [COUNT_WIDTH-1:0]  heal_cnt_q, heal_cnt_d;
	logic [COUNT_WIDTH-1:0]  occ_cnt_q,  occ_cnt_d;

	logic signed [LVL_W-1:0] level_base;
	logic signed [LVL_W:0]   level_sum;
	logic signed [LVL_W-1:0] level_sat;
	logic signed [LVL_W-1:0] jump_ext;
	logic [CMP_W-1:0]        fail_cmp;
	logic [CMP_W-1:0]        aging_cmp;
	logic [CMP_W-1:0]        heal_cmp;
	logic [CMP_W-1:0]        occ_cmp;
	logic                    at_passed;

	assign jump_ext  = LVL_W'(jump_value_q);
	assign at_passed = (fd_q == FD_PASSED);

	always_comb begin
		level_d     = level_q;
		fd_d        = fd_q;
		status_d    = status_q;
		fail_cnt_d  = fail_cnt_q;
		aging_cnt_d = aging_cnt_q;
		heal_cnt_d  = heal_cnt_q;
		occ_cnt_d   = occ_cnt_q;
		level_base  = level_q;
		level_sum   = '0;
		level_sat   = level_q;
		fail_cmp    = '0;
		aging_cmp   = '0;
		heal_cmp    = '0;
		occ_cmp     = '0;

		if (opcode_s1 == OP_REPORT) begin
			if (failed_s1) begin
				// reversal from deep pass territory reloads the jump value first
				level_base = (level_q < LVL_LO_LIM) ? jump_ext : level_q;
				level_sum  = (LVL_W+1)'(level_base) + (LVL_W+1)'({1'b0, step_size_q});
			end else begin
				level_base = (level_q > LVL_HI_LIM) ? jump_ext : level_q;
				level_sum  = (LVL_W+1)'(level_base) - (LVL_W+1)'({1'b0, step_size_q});
			end
			if (level_sum > (LVL_W+1)'(LVL_MAX)) begin
				level_sat = LVL_MAX;
			end else if (level_sum < (LVL_W+1)'(LVL_MIN)) begin
				level_sat = LVL_MIN;
			end else begin
				level_sat = level_sum[LVL_W-1:0];
			end

			if (failed_s1) begin
				level_d = level_base;
				// level frozen once fully qualified failed
				if (fd_q != FD_FAILED) begin
					level_d   = level_sat;
					occ_cnt_d = (occ_cnt_q == '1) ? occ_cnt_q : occ_cnt_q + 1'b1;
					occ_cmp   = CMP_W'(occ_cnt_d);
					if (occ_cmp == CMP_W'(occ_limit_q)) begin
						status_d[ST_OCCURRENCE] = 1'b1;
					end
				end
				status_d[ST_TEST_FAILED] = 1'b1;
			end else begin
				level_d = level_base;
				if (fd_q > FD_PASS_STOP) begin
					level_d = level_sat;
				end
				status_d[ST_TEST_FAILED] = 1'b0;
			end

			// four-level qualification of the new level
			if (level_d >= LVL_HI_LIM) begin
				fd_d = FD_FAILED;
				status_d[ST_QUALIFIED] = 1'b1;
			end else if (!level_d[LVL_W-1]) begin
				// level not negative
				fd_d = FD_PREFAILED;
			end else if (level_d > LVL_LO_LIM) begin
				fd_d = FD_PREPASSED;
			end else begin
				fd_d = FD_PASSED;
			end
		end else begin
			// operation cycle start
			if (fd_q == FD_FAILED) begin
				fail_cnt_d = (fail_cnt_q == '1) ? fail_cnt_q : fail_cnt_q + 1'b1;
			end
			fail_cmp = CMP_W'(fail_cnt_d);
			if (fail_cmp == CMP_W'(failure_thr_q)) begin
				status_d[ST_AGING_BIT]   = 1'b1;
				status_d[ST_HEALING_BIT] = 1'b1;
			end
			if (status_d[ST_AGING_BIT] && at_passed) begin
				aging_cnt_d = (aging_cnt_q == '1) ? aging_cnt_q : aging_cnt_q + 1'b1;
			end
			if (status_d[ST_HEALING_BIT] && at_passed) begin
				heal_cnt_d = (heal_cnt_q == '1) ? heal_cnt_q : heal_cnt_q + 1'b1;
			end
			aging_cmp = CMP_W'(aging_cnt_d);
			heal_cmp  = CMP_W'(heal_cnt_d);
			if (aging_cmp == CMP_W'(aging_thr_q)) begin
				status_d[ST_AGING_BIT] = 1'b0;
			end
			if (heal_cmp == CMP_W'(healing_thr_q)) begin
				status_d[ST_HEALING_BIT] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			fd_q        <= FD_INITIAL;
			status_q    <= '0;
			fail_cnt_q  <= '0;
			aging_cnt_q <= '0;
			heal_cnt_q  <= '0;
			occ_cnt_q   <= '0;
		end else if (valid_s1) begin
			level_q     <= level_d;
			fd_q        <= fd_d;
			status_q    <= status_d;
			fail_cnt_q  <= fail_cnt_d;
			aging_cnt_q <= aging_cnt_d;
			heal_cnt_q  <= heal_cnt_d;
			occ_cnt_q   <= occ_cnt_d;
		end
	end

	// result of the registered beat, pushed into the output buffer in the same cycle
	result_t          res_s1;
	logic [CMP_W-1:0] fail_out;
	logic [CMP_W-1:0] aging_out;
	logic [CMP_W-1:0] heal_out;

	assign fail_out  = CMP_W'(fail_cnt_d);
	assign aging_out = CMP_W'(aging_cnt_d);
	assign heal_out  = CMP_W'(heal_cnt_d);

	always_comb begin
		res_s1.event_status   = status_d;
		res_s1.fault_detect   = fd_d;
		res_s1.debounce_level = level_d;
		res_s1.failure_count  = fail_out[OUT_CNT_W-1:0];
		res_s1.aging_count    = aging_out[OUT_CNT_W-1:0];
		res_s1.healing_count  = heal_out[OUT_CNT_W-1:0];
	end

	logic [RES_W-1:0] oq_head;

	cedq_out_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OQ_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (res_s1),
		.pop       (m_tready),
		.not_empty (m_tvalid),
		.head_data (oq_head),
		.count     (oq_count)
	);

	assign m_tdata = {(M_TDATA_W - RES_W)'(0), oq_head};

	// the buffer can never be asked to hold more beats than it has entries
	assert property (@(posedge clk) disable iff (!arst_n)
		in_flight <= INFL_W'(OQ_DEPTH))
		else $error("output buffer overcommitted");

	// unused status bits stay clear
	assert property (@(posedge clk) disable iff (!arst_n)
		status_q[6:4] == 3'b000)
		else $error("reserved status bits set");

	// qualified value is always one of the five levels
	assert property (@(posedge clk) disable iff (!arst_n)
		fd_q == FD_FAILED || fd_q == FD_PREFAILED || fd_q == FD_INITIAL ||
		fd_q == FD_PREPASSED || fd_q == FD_PASSED)
		else $error("fault detect out of its code set");

	// an accepted beat reaches the buffer on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted beat lost before the buffer");

endmodule
